### rtl/infix_expression_evaluator_top_assert.svh
// assertion macros for the expression evaluator checker
`ifndef INFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
// implication checked every clock, off during reset
`define IEE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define IEE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// shared types and constants of the infix expression evaluator
// ----------------------------------------------------------------------------
`default_nettype none
package iee_pkg;
  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned FracBitsDef   = 16;

  typedef enum logic [1:0] {
    REQ_NUM = 2'd0,
    REQ_OP  = 2'd1,
    REQ_END = 2'd2,
    REQ_NOP = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_DIV0 = 2'd1,
    ERR_OVF  = 2'd2,
    ERR_MAL  = 2'd3
  } err_e;

  // arithmetic unit sequencing
  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} alu_st_e;

  // stack sequencer states
  typedef enum logic [2:0] {
    B_IDLE, B_RD, B_POPB, B_POPA, B_EXEC, B_WAIT, B_OUT
  } bk_st_e;

  // classified token handed from front to back
  typedef struct packed {
    req_e        kind;
    logic [15:0] num;
    op_e         op;
  } tok_t;

  localparam logic [63:0] SatPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SatNeg = 64'h8000_0000_0000_0000;

  // 128-bit magnitude to signed saturated 64-bit value
  function automatic logic [63:0] sat_sign(input logic [127:0] m, input logic neg);
    logic [63:0] r;
    if (neg) begin
      if (m[127:64] != 64'd0 || m[63:0] > SatNeg) r = SatNeg;
      else r = 64'd0 - m[63:0];
    end else begin
      if (m[127:64] != 64'd0 || m[63:0] > SatPos) r = SatPos;
      else r = m[63:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/iee_front.sv
// ----------------------------------------------------------------------------
// iee_front
// token intake: drops unused kinds, two-entry queue towards the back end
// ----------------------------------------------------------------------------
`default_nettype none
module iee_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  output logic              full_o,
  input  wire logic [1:0]   req_type_i,
  input  wire logic [15:0]  number_value_i,
  input  wire logic [1:0]   op_code_i,
  output logic              tok_valid_o,
  output iee_pkg::tok_t     tok_o,
  input  wire logic         tok_take_i
);
  iee_pkg::tok_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          wr, rd;

  assign full_o      = (cnt_q == 2'd2);
  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = mem_q[rp_q];
  // unused token kind never enters the queue
  assign wr = push_i && !full_o && (req_type_i != iee_pkg::REQ_NOP);
  assign rd = tok_take_i && tok_valid_o;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= '{kind: iee_pkg::req_e'(req_type_i), num: number_value_i,
                             op: iee_pkg::op_e'(op_code_i)};
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

### rtl/iee_alu.sv
// ----------------------------------------------------------------------------
// iee_alu
// fixed point add, subtract, multi-cycle multiply and bit-serial divide
// ----------------------------------------------------------------------------
`default_nettype none
module iee_alu #(
  parameter int unsigned FracBits = iee_pkg::FracBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire iee_pkg::op_e op_i,
  input  wire logic [63:0]  a_i,
  input  wire logic [63:0]  b_i,
  output logic              done_o,
  output logic [63:0]       res_o
);
  iee_pkg::alu_st_e st_q, st_d;
  logic [63:0]  x_q, y_q;
  logic         neg_q;
  logic [127:0] acc_q, num_q, qt_q;
  logic [64:0]  r_q;
  logic [6:0]   cnt_q;
  logic [63:0]  res_q;
  logic [63:0]  ma, mb;
  logic [64:0]  r_sh, r_sub;
  logic [63:0]  pp;

  assign ma = a_i[63] ? 64'd0 - a_i : a_i;
  assign mb = b_i[63] ? 64'd0 - b_i : b_i;
  // one 32x32 partial product per cycle
  assign pp = {32'd0, cnt_q[1] ? x_q[63:32] : x_q[31:0]} *
              {32'd0, cnt_q[0] ? y_q[63:32] : y_q[31:0]};
  assign r_sh  = {r_q[63:0], num_q[127]};
  assign r_sub = r_sh - {1'b0, y_q};

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      iee_pkg::A_IDLE: if (start_i) begin
        if (op_i == iee_pkg::OP_MUL) st_d = iee_pkg::A_MUL;
        else if (op_i == iee_pkg::OP_DIV) st_d = iee_pkg::A_DIV;
        else st_d = iee_pkg::A_FIN;
      end
      iee_pkg::A_MUL: if (cnt_q == 7'd3) st_d = iee_pkg::A_FIN;
      iee_pkg::A_DIV: if (cnt_q == 7'd127) st_d = iee_pkg::A_FIN;
      iee_pkg::A_FIN: st_d = iee_pkg::A_IDLE;
      default: st_d = iee_pkg::A_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o = (st_q == iee_pkg::A_FIN);
    res_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= iee_pkg::A_IDLE;
    else st_q <= st_d;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      iee_pkg::A_IDLE: if (start_i) begin
        x_q <= ma; y_q <= mb; neg_q <= a_i[63] ^ b_i[63];
        cnt_q <= 7'd0; acc_q <= '0; r_q <= '0; qt_q <= '0;
        num_q <= {64'd0, ma} << FracBits;
        case (op_i)
          iee_pkg::OP_ADD: begin
            res_q <= a_i + b_i;
            if (a_i[63] == b_i[63] && (a_i + b_i) >> 63 != {63'd0, a_i[63]})
              res_q <= a_i[63] ? iee_pkg::SatNeg : iee_pkg::SatPos;
          end
          iee_pkg::OP_SUB: begin
            res_q <= a_i - b_i;
            if (a_i[63] != b_i[63] && (a_i - b_i) >> 63 != {63'd0, a_i[63]})
              res_q <= a_i[63] ? iee_pkg::SatNeg : iee_pkg::SatPos;
          end
          default: ;
        endcase
      end
      iee_pkg::A_MUL: begin
        acc_q <= acc_q + ({64'd0, pp} << (7'd32 * ({6'd0, cnt_q[1]} + {6'd0, cnt_q[0]})));
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd3)
          res_q <= iee_pkg::sat_sign((acc_q + ({64'd0, pp} << 64)) >> FracBits, neg_q);
      end
      iee_pkg::A_DIV: begin
        num_q <= num_q << 1;
        cnt_q <= cnt_q + 7'd1;
        if (!r_sub[64]) begin
          r_q <= r_sub; qt_q <= {qt_q[126:0], 1'b1};
        end else begin
          r_q <= r_sh; qt_q <= {qt_q[126:0], 1'b0};
        end
        if (cnt_q == 7'd127)
          res_q <= iee_pkg::sat_sign({qt_q[126:0], !r_sub[64]}, neg_q);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/iee_back.sv
// ----------------------------------------------------------------------------
// iee_back
// stack sequencer: operator and value stacks, reductions, result register
// ----------------------------------------------------------------------------
`default_nettype none
module iee_back #(
  parameter int unsigned StackDepth = iee_pkg::StackDepthDef,
  parameter int unsigned FracBits   = iee_pkg::FracBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          tok_valid_i,
  input  wire iee_pkg::tok_t tok_i,
  output logic               tok_take_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output logic signed [63:0] result_value_o,
  output logic [1:0]         error_code_o
);
  localparam int unsigned CW = $clog2(StackDepth + 1);
  localparam int unsigned AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam logic [CW-1:0] Full = CW'(StackDepth);

  iee_pkg::bk_st_e st_q, st_d;

  iee_pkg::op_e ostk [StackDepth];
  logic [63:0]  vstk [StackDepth];
  logic [CW-1:0] oc_q, vc_q;
  iee_pkg::err_e err_q;
  iee_pkg::tok_t tk_q;
  iee_pkg::op_e  top_op_q;
  iee_pkg::op_e  ex_op_q;
  logic [63:0]   rd_q, b_q, a_q;
  logic          res_v_q;
  logic [63:0]   res_q;
  logic [1:0]    rerr_q;
  logic          alu_start, alu_done;
  logic [63:0]   alu_res;
  logic          want_red, is_end;

  iee_alu #(.FracBits(FracBits)) u_alu (
    .clk_i, .rst_ni, .start_i(alu_start), .op_i(ex_op_q),
    .a_i(a_q), .b_i(b_q), .done_o(alu_done), .res_o(alu_res)
  );

  assign is_end = (tk_q.kind == iee_pkg::REQ_END);
  // reduce if no error and end marker or top op binds at least as tightly
  assign want_red = (err_q == iee_pkg::ERR_NONE) && (oc_q != '0) &&
                    (is_end || (top_op_q[1] >= tk_q.op[1]));
  assign alu_start = (st_q == iee_pkg::B_EXEC) &&
                     !(ex_op_q == iee_pkg::OP_DIV && b_q == 64'd0);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      iee_pkg::B_IDLE: if (tok_valid_i) st_d = iee_pkg::B_RD;
      iee_pkg::B_RD: begin
        if (tk_q.kind == iee_pkg::REQ_NUM) st_d = iee_pkg::B_IDLE;
        else if (want_red) st_d = (vc_q < CW'(2)) ? iee_pkg::B_RD : iee_pkg::B_POPB;
        else if (is_end) st_d = res_v_q ? iee_pkg::B_RD : iee_pkg::B_OUT;
        else st_d = iee_pkg::B_IDLE;
      end
      iee_pkg::B_POPB: st_d = iee_pkg::B_POPA;
      iee_pkg::B_POPA: st_d = iee_pkg::B_EXEC;
      iee_pkg::B_EXEC: st_d = alu_start ? iee_pkg::B_WAIT : iee_pkg::B_RD;
      iee_pkg::B_WAIT: if (alu_done) st_d = iee_pkg::B_RD;
      iee_pkg::B_OUT:  st_d = iee_pkg::B_IDLE;
      default: st_d = iee_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    tok_take_o     = (st_q == iee_pkg::B_IDLE) && tok_valid_i;
    empty_o        = !res_v_q;
    result_value_o = res_q;
    error_code_o   = rerr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= iee_pkg::B_IDLE; oc_q <= '0; vc_q <= '0; err_q <= iee_pkg::ERR_NONE;
      res_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (pop_i && res_v_q) res_v_q <= 1'b0;
      case (st_q)
        iee_pkg::B_RD: begin
          if (tk_q.kind == iee_pkg::REQ_NUM) begin
            if (err_q == iee_pkg::ERR_NONE) begin
              if (vc_q == Full) err_q <= iee_pkg::ERR_OVF;
              else vc_q <= vc_q + CW'(1);
            end
          end else if (want_red) begin
            if (vc_q < CW'(2)) err_q <= iee_pkg::ERR_MAL;
            else begin
              oc_q <= oc_q - CW'(1); vc_q <= vc_q - CW'(2);
            end
          end else if (is_end) begin
            if (!res_v_q) begin
              oc_q <= '0; vc_q <= '0; err_q <= iee_pkg::ERR_NONE;
            end
          end else if (err_q == iee_pkg::ERR_NONE) begin
            if (oc_q == Full) err_q <= iee_pkg::ERR_OVF;
            else oc_q <= oc_q + CW'(1);
          end
        end
        iee_pkg::B_EXEC: if (!alu_start) err_q <= iee_pkg::ERR_DIV0;
        iee_pkg::B_WAIT: if (alu_done) vc_q <= vc_q + CW'(1);
        iee_pkg::B_OUT:  res_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // stack memories and token capture
  always_ff @(posedge clk_i) begin
    if (st_q == iee_pkg::B_IDLE && tok_valid_i) tk_q <= tok_i;
    top_op_q <= ostk[AW'(oc_q - CW'(1))];
    rd_q     <= vstk[AW'(vc_q - CW'(1))];
    case (st_q)
      iee_pkg::B_RD: begin
        if (tk_q.kind == iee_pkg::REQ_NUM && err_q == iee_pkg::ERR_NONE && vc_q != Full)
          vstk[AW'(vc_q)] <= {48'd0, tk_q.num} << FracBits;
        if (tk_q.kind == iee_pkg::REQ_OP && !want_red && err_q == iee_pkg::ERR_NONE &&
            oc_q != Full)
          ostk[AW'(oc_q)] <= tk_q.op;
        if (is_end && !want_red && !res_v_q) begin
          rerr_q <= (err_q == iee_pkg::ERR_NONE && vc_q != CW'(1)) ? iee_pkg::ERR_MAL
                    : err_q;
          res_q  <= (err_q == iee_pkg::ERR_NONE && vc_q == CW'(1)) ? vstk[0] : 64'd0;
        end
      end
      // top value and popped operator still hold the pre-pop entries here
      iee_pkg::B_POPB: begin
        b_q     <= rd_q;
        ex_op_q <= top_op_q;
      end
      iee_pkg::B_POPA: a_q <= vstk[AW'(vc_q)];
      iee_pkg::B_WAIT: if (alu_done) vstk[AW'(vc_q)] <= alu_res;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/infix_expression_evaluator_top.sv
// Infix expression evaluator.
// Input channel (push/full): one token per item, a number, an operator
// or an end marker; an item is taken when push is high and full low.
// Result channel (empty/pop): one result per end marker, signed Q47.16
// value and error code; held until popped with pop while empty is low.
// A two-entry token queue sits before the stack sequencer.
// A number is stored on the value stack; an operator or end marker may first
// trigger reductions: add/subtract, multiply (four 32x32 partial products)
// or divide (128-step restoring divider, one quotient bit a cycle).
// An end marker is held while an earlier result waits to be popped;
// further tokens then back up into the queue and full rises.
// Reset empties the queue, both stacks and the result register.
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top
// top level: front intake queue and back stack sequencer
// ----------------------------------------------------------------------------
`default_nettype none
module infix_expression_evaluator_top #(
  parameter int unsigned StackDepth = iee_pkg::StackDepthDef,
  parameter int unsigned FracBits   = iee_pkg::FracBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    req_type_i,
  input  wire logic [15:0]   number_value_i,
  input  wire logic [1:0]    op_code_i,
  output logic               empty,
  input  wire logic          pop,
  output logic signed [63:0] result_value_o,
  output logic [1:0]         error_code_o
);
  logic          tok_valid, tok_take;
  iee_pkg::tok_t tok;

  // token intake
  iee_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .req_type_i, .number_value_i,
    .op_code_i, .tok_valid_o(tok_valid), .tok_o(tok), .tok_take_i(tok_take)
  );

  // evaluation
  iee_back #(.StackDepth(StackDepth), .FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .tok_valid_i(tok_valid), .tok_i(tok), .tok_take_o(tok_take),
    .empty_o(empty), .pop_i(pop), .result_value_o, .error_code_o
  );
endmodule
`default_nettype wire

### rtl/iee_checker.sv
// ----------------------------------------------------------------------------
// iee_checker
// port-level checks of the evaluator
// ----------------------------------------------------------------------------
`default_nettype none
`include "infix_expression_evaluator_top_assert.svh"
module iee_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [63:0] result_value_o,
  input wire logic [1:0]  error_code_o
);
  // a failed expression reports zero
  `IEE_ASSERT_IMP(a_err_zero, clk_i, rst_ni,
    !empty && error_code_o != iee_pkg::ERR_NONE, result_value_o == 64'd0)
  // waiting result holds until popped
  `IEE_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(result_value_o))
  // a popped result leaves the output slot empty
  `IEE_ASSERT_NEXT(a_pop_clears, clk_i, rst_ni, !empty && pop, empty)
  // the queue full flag is never unknown outside reset
  `IEE_ASSERT_IMP(a_full_known, clk_i, rst_ni, 1'b1, !$isunknown(full))
endmodule
bind infix_expression_evaluator_top iee_checker u_iee_checker (.*);
`default_nettype wire

### verif/infix_expression_evaluator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top_tb
// checks every result of the expression evaluator against a predictor of
// the two-stack evaluation; directed corner cases, then random expressions
// under varied idling and a long result hold-off
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top_tb;

  localparam int unsigned Depth     = iee_pkg::StackDepthDef;
  localparam int unsigned Frac      = iee_pkg::FracBitsDef;
  localparam int unsigned CycleCap  = 2000000;
  localparam int unsigned TailWait  = 400;
  localparam int unsigned PhaseToks = 420;

  typedef struct packed {
    logic [63:0]   val;
    iee_pkg::err_e err;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic [1:0]  req_type_i = iee_pkg::REQ_NOP;
  logic [15:0] number_value_i = '0;
  logic [1:0]  op_code_i = iee_pkg::OP_ADD;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic signed [63:0] result_value_o;
  logic [1:0]  error_code_o;

  infix_expression_evaluator_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .number_value_i (number_value_i),
    .op_code_i      (op_code_i),
    .empty          (empty),
    .pop            (pop),
    .result_value_o (result_value_o),
    .error_code_o   (error_code_o)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  iee_pkg::op_e  op_stack [Depth];
  logic [63:0]   val_stack [Depth];
  int unsigned   op_depth;
  int unsigned   val_depth;
  iee_pkg::err_e expr_err;
  outcome_t      pending_results [$];

  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_req_count;

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // fixed point arithmetic of the evaluator
  function automatic logic [63:0] clamp_signed(logic [127:0] mag, logic neg);
    if (neg) begin
      if (mag[127:64] != 0 || mag[63:0] > iee_pkg::SatNeg) return iee_pkg::SatNeg;
      return 64'd0 - mag[63:0];
    end
    if (mag[127:64] != 0 || mag[63:0] > iee_pkg::SatPos) return iee_pkg::SatPos;
    return mag[63:0];
  endfunction

  function automatic logic [63:0] magnitude(logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic int unsigned prec(iee_pkg::op_e o);
    return (o == iee_pkg::OP_MUL || o == iee_pkg::OP_DIV) ? 2 : 1;
  endfunction

  function automatic void flag_error(iee_pkg::err_e e);
    if (expr_err == iee_pkg::ERR_NONE) expr_err = e;
  endfunction

  // pop one operator and two values, push the outcome unless dividing by zero
  function automatic void reduce_top();
    logic [63:0]  a, b, s;
    logic [127:0] wide;
    iee_pkg::op_e o;
    if (op_depth == 0 || val_depth < 2) begin
      flag_error(iee_pkg::ERR_MAL);
      return;
    end
    op_depth--;
    o = op_stack[op_depth];
    val_depth--;
    b = val_stack[val_depth];
    val_depth--;
    a = val_stack[val_depth];
    case (o)
      iee_pkg::OP_ADD: begin
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? iee_pkg::SatNeg : iee_pkg::SatPos;
      end
      iee_pkg::OP_SUB: begin
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? iee_pkg::SatNeg : iee_pkg::SatPos;
      end
      iee_pkg::OP_MUL: begin
        wide = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        s = clamp_signed(wide >> Frac, a[63] ^ b[63]);
      end
      default: begin
        if (b == 0) begin
          flag_error(iee_pkg::ERR_DIV0);
          return;
        end
        wide = ({64'd0, magnitude(a)} << Frac) / {64'd0, magnitude(b)};
        s = clamp_signed(wide, a[63] ^ b[63]);
      end
    endcase
    val_stack[val_depth] = s;
    val_depth++;
  endfunction

  // advance the predictor by one accepted item
  function automatic void evaluate_token(iee_pkg::req_e k, logic [15:0] n, iee_pkg::op_e o);
    outcome_t r;
    case (k)
      iee_pkg::REQ_NUM: begin
        if (expr_err != iee_pkg::ERR_NONE) return;
        if (val_depth >= Depth) begin
          flag_error(iee_pkg::ERR_OVF);
          return;
        end
        val_stack[val_depth] = {48'd0, n} << Frac;
        val_depth++;
      end
      iee_pkg::REQ_OP: begin
        while (expr_err == iee_pkg::ERR_NONE && op_depth > 0 &&
               prec(op_stack[op_depth-1]) >= prec(o))
          reduce_top();
        if (expr_err != iee_pkg::ERR_NONE) return;
        if (op_depth >= Depth) begin
          flag_error(iee_pkg::ERR_OVF);
          return;
        end
        op_stack[op_depth] = o;
        op_depth++;
      end
      iee_pkg::REQ_END: begin
        while (expr_err == iee_pkg::ERR_NONE && op_depth > 0) reduce_top();
        if (expr_err == iee_pkg::ERR_NONE && val_depth != 1) flag_error(iee_pkg::ERR_MAL);
        r.val = (expr_err == iee_pkg::ERR_NONE) ? val_stack[0] : 64'd0;
        r.err = expr_err;
        pending_results = {pending_results, r};
        op_depth = 0;
        val_depth = 0;
        expr_err = iee_pkg::ERR_NONE;
      end
      default: ;
    endcase
  endfunction

  // offer one item and wait until it is taken
  task automatic send_token(iee_pkg::req_e k, logic [15:0] n, iee_pkg::op_e o);
    push           <= 1'b1;
    req_type_i     <= k;
    number_value_i <= n;
    op_code_i      <= o;
    do @(posedge clk_i); while (full);
    evaluate_token(k, n, o);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic put_num(logic [15:0] n);
    send_token(iee_pkg::REQ_NUM, n, iee_pkg::op_e'($urandom_range(3)));
  endtask

  task automatic put_op(iee_pkg::op_e o);
    send_token(iee_pkg::REQ_OP, 16'($urandom), o);
  endtask

  task automatic put_end();
    send_token(iee_pkg::REQ_END, 16'($urandom), iee_pkg::op_e'($urandom_range(3)));
  endtask

  // result side: random stalls, long hold-off on request, field checks
  initial begin : result_check
    int unsigned hold_left, hold_seen;
    outcome_t    want;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result value=%h err=%0d", $time,
                   result_value_o, error_code_o);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_value_o !== want.val) begin
            $display("%0t: result_value expected %h actual %h", $time,
                     want.val, result_value_o);
            fail_count++;
          end
          if (error_code_o !== want.err) begin
            $display("%0t: error_code expected %0d actual %0d", $time,
                     want.err, error_code_o);
            fail_count++;
          end
        end
      end
      if (hold_seen != hold_req_count) begin
        hold_seen = hold_req_count;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // stop offering and wait for every predicted result
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_number(output logic [15:0] n);
    case ($urandom_range(3))
      0:       n = 16'($urandom_range(3));
      1:       n = 16'hFFFF - 16'($urandom_range(3));
      default: n = 16'($urandom);
    endcase
  endtask

  // one well-formed expression with random content, or a broken one
  task automatic random_expression(inout int unsigned toks);
    logic [15:0] n;
    int unsigned len;
    if ($urandom_range(99) < 85) begin
      len = $urandom_range(7);
      random_number(n);
      put_num(n);
      for (int unsigned i = 0; i < len; i++) begin
        put_op(iee_pkg::op_e'($urandom_range(3)));
        random_number(n);
        put_num(n);
      end
      toks += 2 * len + 2;
    end else begin
      len = $urandom_range(1, 20);
      for (int unsigned i = 0; i < len; i++) begin
        random_number(n);
        send_token(iee_pkg::req_e'($urandom_range(3)), n,
                   iee_pkg::op_e'($urandom_range(3)));
      end
      toks += len + 1;
    end
    put_end();
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // lone number
    put_num(16'hFFFF); put_end();
    // precedence: 1 + 2 * 3 - 8 / 4
    put_num(16'd1); put_op(iee_pkg::OP_ADD); put_num(16'd2); put_op(iee_pkg::OP_MUL);
    put_num(16'd3); put_op(iee_pkg::OP_SUB); put_num(16'd8); put_op(iee_pkg::OP_DIV);
    put_num(16'd4); put_end();
    // negative and fractional division
    put_num(16'd0); put_op(iee_pkg::OP_SUB); put_num(16'd7); put_op(iee_pkg::OP_DIV);
    put_num(16'd2); put_end();
    // division by zero, tokens after it ignored
    put_num(16'd5); put_op(iee_pkg::OP_DIV); put_num(16'd0); put_op(iee_pkg::OP_ADD);
    put_num(16'd1); put_end();
    // positive saturation, then a saturated product subtracted from zero
    put_num(16'hFFFF); put_op(iee_pkg::OP_MUL); put_num(16'hFFFF); put_op(iee_pkg::OP_MUL);
    put_num(16'hFFFF); put_op(iee_pkg::OP_MUL); put_num(16'hFFFF); put_end();
    put_num(16'd0); put_op(iee_pkg::OP_SUB); put_num(16'hFFFF); put_op(iee_pkg::OP_MUL);
    put_num(16'hFFFF); put_op(iee_pkg::OP_MUL); put_num(16'hFFFF); put_op(iee_pkg::OP_MUL);
    put_num(16'hFFFF); put_end();
    // empty expression, operator without operands, operands left over
    put_end();
    put_op(iee_pkg::OP_ADD); put_end();
    put_num(16'd1); put_num(16'd2); put_end();
    // unused token kind is ignored
    put_num(16'd3); send_token(iee_pkg::REQ_NOP, 16'hFFFF, iee_pkg::OP_DIV); put_end();
    // value stack overflow
    for (int unsigned i = 0; i < Depth + 1; i++) put_num(16'(i));
    put_end();
    wait_drained();
  endtask

  task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                   bit with_hold);
    int unsigned toks;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    toks = 0;
    if (with_hold) hold_req_count++;
    while (toks < PhaseToks) random_expression(toks);
    wait_drained();
  endtask

  initial begin
    fail_count     = 0;
    cycle_count    = 0;
    hold_req_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    op_depth       = 0;
    val_depth      = 0;
    expr_err       = iee_pkg::ERR_NONE;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(0, 0, 1'b1);
    test_random_phase(70, 0, 1'b0);
    test_random_phase(0, 70, 1'b0);
    test_random_phase(25, 25, 1'b0);
    repeat (TailWait) @(posedge clk_i);
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
